FILE: rtl/rrfp_pkg.sv
// Shared types and codes for the row record field parser.
// No dependencies; imported by every module of the block.
package rrfp_pkg;

  // Schema limits and field widths
  localparam int MAX_COLUMNS = 16;
  localparam int COL_W       = 5;
  localparam int TYPE_BITS   = 16;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 16;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_COLUMN_COUNT      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COLUMN_IS_INTEGER = 2'd1;

  // Byte role codes
  localparam logic [2:0] ROLE_INT     = 3'd0;
  localparam logic [2:0] ROLE_LEN_LO  = 3'd1;
  localparam logic [2:0] ROLE_LEN_HI  = 3'd2;
  localparam logic [2:0] ROLE_TEXT    = 3'd3;
  localparam logic [2:0] ROLE_TRAIL   = 3'd4;

  // Record status codes
  localparam logic [1:0] STAT_BUSY    = 2'd0;
  localparam logic [1:0] STAT_DONE    = 2'd1;
  localparam logic [1:0] STAT_TRUNC   = 2'd2;

  // Schema as held in the configuration registers
  typedef struct packed {
    logic [COL_W-1:0]     column_count;
    logic [TYPE_BITS-1:0] column_is_integer;
  } cfg_t;

  // One registered input request
  typedef struct packed {
    logic [7:0] record_byte;
    logic       last_of_record;
  } item_t;

endpackage

FILE: rtl/rrfp_in_stage.sv
// Input register stage of the row record field parser.
// Depends on rrfp_pkg for the item type.
module rrfp_in_stage (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic [7:0]     record_byte,
  input  logic           last_of_record,
  output logic           item_valid,
  input  logic           item_ready,
  output rrfp_pkg::item_t item
);
  import rrfp_pkg::*;

  logic in_take;

  // Accept a new request when empty or when the held one moves on
  assign in_ready = !item_valid || item_ready;
  assign in_take  = in_valid && in_ready;

  // Valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_take) begin
      item_valid <= 1'b1;
    end else if (item_ready) begin
      item_valid <= 1'b0;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (in_take) begin
      item.record_byte    <= record_byte;
      item.last_of_record <= last_of_record;
    end
  end

endmodule

FILE: rtl/rrfp_parse_core.sv
// Parse state and result register of the row record field parser.
// Depends on rrfp_pkg for schema, item type and role/status codes.
module rrfp_parse_core (
  input  logic                         clk,
  input  logic                         rst,
  input  rrfp_pkg::cfg_t               cfg,
  input  logic                         item_valid,
  output logic                         item_ready,
  input  rrfp_pkg::item_t              item,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [rrfp_pkg::COL_W-1:0]   column_index,
  output logic [2:0]                   byte_role,
  output logic [7:0]                   byte_out,
  output logic signed [31:0]           field_value,
  output logic                         value_valid,
  output logic                         record_end,
  output logic [1:0]                   record_status
);
  import rrfp_pkg::*;

  typedef enum logic [1:0] {
    PH_START,
    PH_INT,
    PH_LEN_HI,
    PH_TEXT
  } phase_t;

  phase_t           phase, phase_next;
  logic [COL_W-1:0] cur_col, cur_col_next;
  logic [1:0]       int_cnt, int_cnt_next;
  logic [15:0]      text_left, text_left_next;
  logic [31:0]      acc, acc_next;

  logic [COL_W-1:0] count;
  logic             in_schema;
  logic             is_int;
  logic             take;
  logic [15:0]      len;
  logic [COL_W-1:0] res_col;
  logic [2:0]       res_role;
  logic [31:0]      res_value;
  logic             res_valid;
  logic [1:0]       res_status;

  assign item_ready = !out_valid || out_ready;
  assign take       = item_valid && item_ready;

  // Effective column count and type of the current column
  assign count = (cfg.column_count > COL_W'(MAX_COLUMNS)) ? COL_W'(MAX_COLUMNS)
                                                          : cfg.column_count;
  assign in_schema = cur_col < count;
  assign is_int    = (cur_col < COL_W'(TYPE_BITS)) ?
                     cfg.column_is_integer[cur_col[$clog2(TYPE_BITS)-1:0]] : 1'b0;
  assign len       = {item.record_byte, acc[7:0]};

  // Next state and result for the held byte
  always_comb begin
    phase_next     = phase;
    cur_col_next   = cur_col;
    int_cnt_next   = int_cnt;
    text_left_next = text_left;
    acc_next       = acc;
    res_col        = cur_col;
    res_role       = ROLE_TRAIL;
    res_value      = '0;
    res_valid      = 1'b0;
    res_status     = STAT_BUSY;

    if (!in_schema) begin
      res_col = count;
    end else begin
      case (phase)
        PH_START: begin
          acc_next = {24'd0, item.record_byte};
          if (is_int) begin
            res_role     = ROLE_INT;
            int_cnt_next = 2'd1;
            phase_next   = PH_INT;
          end else begin
            res_role   = ROLE_LEN_LO;
            phase_next = PH_LEN_HI;
          end
        end
        PH_INT: begin
          res_role = ROLE_INT;
          case (int_cnt)
            2'd0:    acc_next[7:0]   = acc[7:0]   | item.record_byte;
            2'd1:    acc_next[15:8]  = acc[15:8]  | item.record_byte;
            2'd2:    acc_next[23:16] = acc[23:16] | item.record_byte;
            default: acc_next[31:24] = acc[31:24] | item.record_byte;
          endcase
          if (int_cnt == 2'd3) begin
            res_value      = acc_next;
            res_valid      = 1'b1;
            cur_col_next   = cur_col + 1'b1;
            phase_next     = PH_START;
            int_cnt_next   = 2'd0;
            text_left_next = '0;
          end else begin
            int_cnt_next = int_cnt + 1'b1;
          end
        end
        PH_LEN_HI: begin
          res_role  = ROLE_LEN_HI;
          res_value = {16'd0, len};
          res_valid = 1'b1;
          if (len == 16'd0) begin
            cur_col_next   = cur_col + 1'b1;
            phase_next     = PH_START;
            int_cnt_next   = 2'd0;
            text_left_next = '0;
          end else begin
            text_left_next = len;
            phase_next     = PH_TEXT;
          end
        end
        default: begin
          res_role = ROLE_TEXT;
          if (text_left <= 16'd1) begin
            cur_col_next   = cur_col + 1'b1;
            phase_next     = PH_START;
            int_cnt_next   = 2'd0;
            text_left_next = '0;
          end else begin
            text_left_next = text_left - 1'b1;
          end
        end
      endcase
    end

    // Record end: report completeness, then restart parsing
    if (item.last_of_record) begin
      res_status     = (cur_col_next >= count) ? STAT_DONE : STAT_TRUNC;
      cur_col_next   = '0;
      phase_next     = PH_START;
      int_cnt_next   = 2'd0;
      text_left_next = '0;
      acc_next       = '0;
    end
  end

  // Parse state and accumulator
  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_START;
      cur_col   <= '0;
      int_cnt   <= 2'd0;
      text_left <= '0;
      acc       <= '0;
    end else if (take) begin
      phase     <= phase_next;
      cur_col   <= cur_col_next;
      int_cnt   <= int_cnt_next;
      text_left <= text_left_next;
      acc       <= acc_next;
    end
  end

  // Result register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Result register payload
  always_ff @(posedge clk) begin
    if (take) begin
      column_index  <= res_col;
      byte_role     <= res_role;
      byte_out      <= item.record_byte;
      field_value   <= res_value;
      value_valid   <= res_valid;
      record_end    <= item.last_of_record;
      record_status <= res_status;
    end
  end

  // Column pointer never passes the schema limit
  a_col_bound: assert property (@(posedge clk) disable iff (rst)
    cur_col <= COL_W'(MAX_COLUMNS))
    else $error("column pointer beyond schema limit");

  // A record end restarts parsing at the first column
  a_end_restart: assert property (@(posedge clk) disable iff (rst)
    take && item.last_of_record |=> cur_col == '0 && phase == PH_START)
    else $error("parse state not cleared after record end");

  // Status only on the record's last byte
  a_status_end: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((record_status != STAT_BUSY) == record_end))
    else $error("record status without record end");

  // Values only on integer or length-high bytes
  a_value_role: assert property (@(posedge clk) disable iff (rst)
    out_valid && value_valid |-> (byte_role == ROLE_INT || byte_role == ROLE_LEN_HI))
    else $error("value reported on wrong byte role");

endmodule

FILE: rtl/row_record_field_parser.sv
// Row record field parser: top level with configuration registers.
// Depends on rrfp_pkg, rrfp_in_stage and rrfp_parse_core.
//
// Usage:
//   Row bytes enter on the in channel (in_valid/in_ready), one request per
//   byte with last_of_record marking the row's final byte. Each byte gives
//   exactly one result on the out channel (out_valid/out_ready): its
//   column, its role, any completed integer or text length, and on the
//   last byte the record status.
//   The schema is written on the cfg channel (cfg_valid/cfg_ready,
//   cfg_index, cfg_data): index 0 column count, index 1 the per-column
//   integer bits. Writes are always taken; write only while idle.
// Timing:
//   An accepted byte is loaded into the input register; the parse step
//   then loads the result register from it, where it waits for the
//   receiver. One byte per cycle is sustained while out_ready stays high;
//   the parse state update is a loop through the parse state registers.
// Reset and stall:
//   rst clears the schema, the parse state and both valid flags. When the
//   receiver holds out_ready low the result register holds, one more byte
//   waits in the input register, and in_ready then drops.
module row_record_field_parser (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [rrfp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rrfp_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [7:0]                      record_byte,
  input  logic                            last_of_record,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [rrfp_pkg::COL_W-1:0]      column_index,
  output logic [2:0]                      byte_role,
  output logic [7:0]                      byte_out,
  output logic signed [31:0]              field_value,
  output logic                            value_valid,
  output logic                            record_end,
  output logic [1:0]                      record_status
);
  import rrfp_pkg::*;

  cfg_t  cfg;
  item_t item;
  logic  item_valid;
  logic  item_ready;

  assign cfg_ready = 1'b1;

  // Schema registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_COLUMN_COUNT:      cfg.column_count      <= cfg_data[COL_W-1:0];
        REG_COLUMN_IS_INTEGER: cfg.column_is_integer <= cfg_data[TYPE_BITS-1:0];
        default: ;
      endcase
    end
  end

  rrfp_in_stage u_in_stage (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .record_byte    (record_byte),
    .last_of_record (last_of_record),
    .item_valid     (item_valid),
    .item_ready     (item_ready),
    .item           (item)
  );

  rrfp_parse_core u_parse_core (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .item_valid    (item_valid),
    .item_ready    (item_ready),
    .item          (item),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .column_index  (column_index),
    .byte_role     (byte_role),
    .byte_out      (byte_out),
    .field_value   (field_value),
    .value_valid   (value_valid),
    .record_end    (record_end),
    .record_status (record_status)
  );

endmodule

FILE: verif/rrfp_field_checker.sv
// Result checker for the row record field parser: follows schema writes,
// predicts one result per accepted row byte and compares results in order.
// Depends on rrfp_pkg for widths, register indexes, role and status codes.
module rrfp_field_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  logic [rrfp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rrfp_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            in_valid,
  input  logic                            in_ready,
  input  logic [7:0]                      record_byte,
  input  logic                            last_of_record,
  input  logic                            out_valid,
  input  logic                            out_ready,
  input  logic [rrfp_pkg::COL_W-1:0]      column_index,
  input  logic [2:0]                      byte_role,
  input  logic [7:0]                      byte_out,
  input  logic signed [31:0]              field_value,
  input  logic                            value_valid,
  input  logic                            record_end,
  input  logic [1:0]                      record_status,
  output int                              error_count,
  output int                              pending,
  output int                              results_checked,
  output int                              records_closed,
  output int                              records_truncated
);
  import rrfp_pkg::*;

  typedef enum logic [1:0] {PH_START, PH_INT, PH_LEN_HI, PH_TEXT} parse_phase_t;

  typedef struct packed {
    logic [COL_W-1:0] column;
    logic [2:0]       role;
    logic [7:0]       data;
    logic [31:0]      value;
    logic             valid;
    logic             rec_end;
    logic [1:0]       status;
  } field_result_t;

  // Schema copy and parse state
  logic [COL_W-1:0]     sch_count;
  logic [TYPE_BITS-1:0] sch_is_int;
  logic [COL_W-1:0]     cur_col;
  parse_phase_t         phase;
  logic [1:0]           int_cnt;
  logic [15:0]          text_left;
  logic [31:0]          acc;

  field_result_t        expected_q[$];
  field_result_t        want;

  function automatic void clear_parse();
    cur_col   = '0;
    phase     = PH_START;
    int_cnt   = '0;
    text_left = '0;
    acc       = '0;
  endfunction

  function automatic void next_column();
    cur_col   = cur_col + 1'b1;
    phase     = PH_START;
    int_cnt   = '0;
    text_left = '0;
  endfunction

  // Advance the parse by one byte and return the result it should produce
  function automatic field_result_t parse_byte(input logic [7:0] b, input logic last);
    field_result_t    r;
    logic [COL_W-1:0] eff_count;
    logic             is_int;
    logic [15:0]      len;
    r         = '0;
    r.data    = b;
    r.role    = ROLE_TRAIL;
    r.rec_end = last;
    r.status  = STAT_BUSY;
    r.column  = cur_col;
    eff_count = (sch_count > MAX_COLUMNS) ? COL_W'(MAX_COLUMNS) : sch_count;
    if (cur_col >= eff_count) begin
      r.column = eff_count;
    end else begin
      // columns past the type bits count as text
      is_int = (cur_col < TYPE_BITS) && sch_is_int[cur_col[3:0]];
      case (phase)
        PH_START: begin
          acc = {24'd0, b};
          if (is_int) begin
            r.role  = ROLE_INT;
            int_cnt = 2'd1;
            phase   = PH_INT;
          end else begin
            r.role = ROLE_LEN_LO;
            phase  = PH_LEN_HI;
          end
        end
        PH_INT: begin
          r.role = ROLE_INT;
          acc    = acc | ({24'd0, b} << (8 * int_cnt));
          if (int_cnt == 2'd3) begin
            r.value = acc;
            r.valid = 1'b1;
            next_column();
          end else begin
            int_cnt = int_cnt + 1'b1;
          end
        end
        PH_LEN_HI: begin
          len     = {b, acc[7:0]};
          r.role  = ROLE_LEN_HI;
          r.value = {16'd0, len};
          r.valid = 1'b1;
          if (len == 16'd0) begin
            next_column();  // empty text closes the column here
          end else begin
            text_left = len;
            phase     = PH_TEXT;
          end
        end
        default: begin
          r.role = ROLE_TEXT;
          if (text_left <= 16'd1) next_column();
          else text_left = text_left - 1'b1;
        end
      endcase
    end
    // record end: report completeness, then back to the first column
    if (last) begin
      r.status = (cur_col >= eff_count) ? STAT_DONE : STAT_TRUNC;
      clear_parse();
    end
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [31:0] exp_v,
                                      input logic [31:0] got_v);
    if (got_v !== exp_v) begin
      error_count++;
      $display("[%0t] %s mismatch: expected 0x%0h, actual 0x%0h", $time, name, exp_v, got_v);
    end
  endfunction

  // Watch all three channels at the rising edge
  always @(posedge clk) begin
    if (rst) begin
      sch_count  = '0;
      sch_is_int = '0;
      clear_parse();
      expected_q.delete();
      error_count       = 0;
      pending           = 0;
      results_checked   = 0;
      records_closed    = 0;
      records_truncated = 0;
    end else begin
      // compare a returned result against the oldest prediction
      if (out_valid && out_ready) begin
        results_checked++;
        if (expected_q.size() == 0) begin
          error_count++;
          $display("[%0t] unexpected result: expected none, actual col %0d role %0d byte 0x%0h",
                   $time, column_index, byte_role, byte_out);
        end else begin
          want = expected_q.pop_front();
          check_field("column_index",  want.column,  column_index);
          check_field("byte_role",     want.role,    byte_role);
          check_field("byte_out",      want.data,    byte_out);
          check_field("field_value",   want.value,   field_value);
          check_field("value_valid",   want.valid,   value_valid);
          check_field("record_end",    want.rec_end, record_end);
          check_field("record_status", want.status,  record_status);
          if (want.rec_end) records_closed++;
          if (want.status == STAT_TRUNC) records_truncated++;
        end
      end
      // schema writes
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_COLUMN_COUNT) sch_count = cfg_data[COL_W-1:0];
        else if (cfg_index == REG_COLUMN_IS_INTEGER) sch_is_int = cfg_data[TYPE_BITS-1:0];
      end
      // accepted row byte
      if (in_valid && in_ready) begin
        expected_q.insert(expected_q.size(), parse_byte(record_byte, last_of_record));
      end
      pending = expected_q.size();
    end
  end

endmodule

FILE: verif/row_record_field_parser_tb.sv
// Testbench top for the row record field parser: clock, reset, schema
// writes, row byte requests and output back-pressure; verdict at the end.
// Depends on rrfp_pkg, row_record_field_parser and rrfp_field_checker.
module row_record_field_parser_tb;
  import rrfp_pkg::*;

  localparam int LIMIT_CYCLES = 200000;
  localparam int HOLD_CYCLES  = 60;
  localparam int PHASE_ITEMS  = 67;
  localparam int NUM_PHASES   = 6;
  // index with no register behind it; writes there must change nothing
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  logic                  clk            = 1'b0;
  logic                  rst            = 1'b1;
  logic                  cfg_valid      = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index      = '0;
  logic [CFG_DATA_W-1:0] cfg_data       = '0;
  logic                  in_valid       = 1'b0;
  logic [7:0]            record_byte    = '0;
  logic                  last_of_record = 1'b0;
  logic                  out_ready      = 1'b0;

  logic                  cfg_ready;
  logic                  in_ready;
  logic                  out_valid;
  logic [COL_W-1:0]      column_index;
  logic [2:0]            byte_role;
  logic [7:0]            byte_out;
  logic signed [31:0]    field_value;
  logic                  value_valid;
  logic                  record_end;
  logic [1:0]            record_status;

  int errors, pending, results_checked, records_closed, records_truncated;

  // Stimulus control
  logic             quiet     = 1'b0;
  logic             hold_req  = 1'b0;
  logic             hold_done = 1'b0;
  int               stall_left  = 0;
  int               rx_cycle    = 0;
  int               sent_count  = 0;
  int               cycle_count = 0;
  logic [COL_W-1:0] cur_count   = '0;
  logic [15:0]      cur_types   = '0;
  logic [7:0]       row_q[$];
  logic [COL_W-1:0] ph_count[NUM_PHASES];
  logic [15:0]      ph_types[NUM_PHASES];

  row_record_field_parser DUT (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .record_byte(record_byte), .last_of_record(last_of_record),
    .out_valid(out_valid), .out_ready(out_ready),
    .column_index(column_index), .byte_role(byte_role), .byte_out(byte_out),
    .field_value(field_value), .value_valid(value_valid),
    .record_end(record_end), .record_status(record_status)
  );

  rrfp_field_checker u_checker (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .record_byte(record_byte), .last_of_record(last_of_record),
    .out_valid(out_valid), .out_ready(out_ready),
    .column_index(column_index), .byte_role(byte_role), .byte_out(byte_out),
    .field_value(field_value), .value_valid(value_valid),
    .record_end(record_end), .record_status(record_status),
    .error_count(errors), .pending(pending), .results_checked(results_checked),
    .records_closed(records_closed), .records_truncated(records_truncated)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("[%0t] timeout with %0d results outstanding", $time, pending);
      $display("row_record_field_parser test failed");
      $finish;
    end
  end

  // Receiver: random stall bursts, calm stretches, and one long hold-off
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      rx_cycle++;
      if (stall_left == 0) begin
        if (hold_req && !hold_done) begin
          stall_left = HOLD_CYCLES;
          hold_done  = 1'b1;
        end else if (!quiet && (rx_cycle % 150) >= 50 && $urandom_range(0, 4) == 0) begin
          stall_left = $urandom_range(1, 10);
        end
      end
      if (stall_left != 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Write both schema registers; optionally poke the unused index as well
  task automatic program_schema(input logic [COL_W-1:0] count, input logic [15:0] types,
                                input bit poke_spare);
    logic [10:0] junk;
    junk = 11'($urandom_range(0, 2047));
    cfg_valid <= 1'b1;
    cfg_index <= REG_COLUMN_COUNT;
    cfg_data  <= {junk, count};  // upper bits are don't-care
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_index <= REG_COLUMN_IS_INTEGER;
    cfg_data  <= types;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    if (poke_spare) begin
      cfg_index <= REG_SPARE;
      cfg_data  <= 16'($urandom_range(0, 65535));
      do @(posedge clk); while (!cfg_ready);
      @(negedge clk);
    end
    cfg_valid <= 1'b0;
    cur_count = count;
    cur_types = types;
  endtask

  // One byte request, with an occasional idle burst in front of it
  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    if (!quiet && (sent_count % 80) >= 25 && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 10);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid       <= 1'b1;
    record_byte    <= b;
    last_of_record <= last;
    do @(posedge clk); while (!in_ready);
    sent_count++;
    @(negedge clk);
  endtask

  task automatic send_row();
    for (int i = 0; i < row_q.size(); i++) send_byte(row_q[i], i == row_q.size() - 1);
  endtask

  // Stop offering and wait until every predicted result has come back
  task automatic drain();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Add one byte at the end of the row being built
  task automatic append_byte(input logic [7:0] b);
    row_q.insert(row_q.size(), b);
  endtask

  // Build a row for the current schema: mostly well formed, some cut short,
  // some with an oversized text length, a few pure noise
  task automatic build_row(output int core_n);
    int eff, c, len, nchar, pick, cut;
    bit broken;
    row_q.delete();
    broken = 1'b0;
    eff    = (cur_count > MAX_COLUMNS) ? MAX_COLUMNS : cur_count;
    pick   = $urandom_range(0, 19);
    if (pick == 0) begin
      repeat ($urandom_range(1, 6)) append_byte(8'($urandom_range(0, 255)));
    end else begin
      c = 0;
      while (c < eff && !broken) begin
        if (cur_types[c]) begin
          repeat (4) append_byte(8'($urandom_range(0, 255)));
        end else begin
          len = $urandom_range(0, 15);
          if (len < 3) len = 0;
          else if (len == 15) len = $urandom_range(9, 65535);
          else len = $urandom_range(1, 6);
          append_byte(len[7:0]);
          append_byte(len[15:8]);
          nchar = len;
          if (len > 8) begin
            // long text: the row ends inside it
            nchar  = $urandom_range(0, 3);
            broken = 1'b1;
          end
          repeat (nchar) append_byte(8'($urandom_range(0, 255)));
        end
        c++;
      end
      if (!broken && pick <= 3 && row_q.size() > 1) begin
        cut = $urandom_range(1, row_q.size());
        while (row_q.size() > cut) void'(row_q.pop_back());
      end
    end
    if (row_q.size() == 0) append_byte(8'($urandom_range(0, 255)));
    core_n = row_q.size();
    if (pick > 3) repeat ($urandom_range(0, 2)) append_byte(8'($urandom_range(0, 255)));
  endtask

  initial begin
    int items, core;
    ph_count[0] = 5'd1;  ph_types[0] = 16'($urandom_range(0, 65535));
    ph_count[1] = 5'd16; ph_types[1] = 16'hFFFF;
    ph_count[2] = 5'd31; ph_types[2] = 16'($urandom_range(0, 65535));
    ph_count[3] = 5'd5;  ph_types[3] = 16'h0000;
    ph_count[4] = 5'($urandom_range(2, 15));  ph_types[4] = 16'($urandom_range(0, 65535));
    ph_count[5] = 5'($urandom_range(17, 30)); ph_types[5] = 16'($urandom_range(0, 65535));

    repeat (5) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // empty schema: every byte trails, the row closes complete
    row_q = '{8'h00, 8'hFF};
    send_row();
    drain();

    // integer then text: all-ones integer, empty text, trailing bytes
    program_schema(5'd2, 16'h0001, 1'b1);
    row_q = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'hA5, 8'h5A};
    send_row();
    // most negative integer, two-char text, ends exactly on the last column
    row_q = '{8'h00, 8'h00, 8'h00, 8'h80, 8'h02, 8'h00, 8'h41, 8'h62};
    send_row();
    drain();

    // schema change mid-row: column 1 turns from integer to text
    program_schema(5'd2, 16'h0003, 1'b0);
    send_byte(8'h78, 1'b0);
    send_byte(8'h56, 1'b0);
    send_byte(8'h34, 1'b0);
    send_byte(8'h12, 1'b0);
    drain();
    program_schema(5'd2, 16'h0001, 1'b0);
    // maximum text length, row cut after one char
    row_q = '{8'hFF, 8'hFF, 8'h7F};
    send_row();

    // random rows under several schemas
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      drain();
      if (ph == NUM_PHASES - 1) quiet <= 1'b1;
      program_schema(ph_count[ph], ph_types[ph], 1'b0);
      if (ph == 1) hold_req <= 1'b1;
      items = 0;
      while (items < PHASE_ITEMS) begin
        build_row(core);
        send_row();
        items += core;
      end
    end
    drain();
    repeat (10) @(negedge clk);

    $display("Covered %0d results over %0d rows (%0d truncated) under 10 schema settings,",
             results_checked, records_closed, records_truncated);
    $display("with random stalls on both sides and a %0d-cycle output hold-off.",
             HOLD_CYCLES);
    if (errors == 0) begin
      $display("row_record_field_parser test passed");
    end else begin
      $display("row_record_field_parser test failed");
    end
    $finish;
  end

endmodule
